/* design/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, types and the arctangent table for the quaternion to
// euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 14;

   localparam int IN_W    = 16;
   localparam int PROD_W  = 2 * IN_W;
   localparam int Q_W     = 34;                  // q.28 sums of products
   localparam int VEC_W   = FRAC_BITS + 8;       // cordic vector, with growth
   localparam int ACC_W   = 32;                  // angle in 2^-22 degree
   localparam int MAG_W   = 28;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int RAD_IN_W = SQ_W + 1;
   localparam int ROOT_W  = 29;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int ROLL_W  = 15;
   localparam int PITCH_W = 14;
   localparam int YAW_W   = 15;

   localparam int CORDIC_EXT_W = VEC_W + Q_W + 2;
   localparam int VEC_SHIFT    = 30 - FRAC_BITS;

   localparam int FRONT_LAT  = 5;
   localparam int PIPE_LATENCY = FRONT_LAT + ROOT_W + 1 + CORDIC_STAGES + 1;

   localparam logic signed [Q_W-1:0]   Q_ONE       = Q_W'(64'sd268435456);
   localparam logic signed [ACC_W-1:0] HALF_TURN   = 32'sd754974720;
   localparam logic signed [ACC_W-1:0] PITCH_FORCE = 32'sd377487360;
   localparam int ROLL_LIM   = 11520;
   localparam int PITCH_LIM  = 5760;
   localparam int UNITS_FULL = 23040;

   typedef struct packed {
      logic signed [Q_W-1:0] roll_sn;
      logic signed [Q_W-1:0] roll_cs;
      logic signed [Q_W-1:0] yaw_sn;
      logic signed [Q_W-1:0] yaw_cs;
      logic signed [Q_W-1:0] pitch_sp;
      logic                  clamp;
   } angle_args_type;

   function automatic logic signed [ACC_W-1:0] atan_val(input int idx);
      case (idx)
         0:  return 32'sd188743680;
         1:  return 32'sd111421900;
         2:  return 32'sd58872272;
         3:  return 32'sd29884485;
         4:  return 32'sd15000234;
         5:  return 32'sd7507429;
         6:  return 32'sd3754631;
         7:  return 32'sd1877430;
         8:  return 32'sd938729;
         9:  return 32'sd469366;
         10: return 32'sd234683;
         11: return 32'sd117342;
         12: return 32'sd58671;
         13: return 32'sd29335;
         14: return 32'sd14668;
         15: return 32'sd7334;
         16: return 32'sd3667;
         17: return 32'sd1833;
         18: return 32'sd917;
         19: return 32'sd458;
         20: return 32'sd229;
         21: return 32'sd115;
         22: return 32'sd57;
         23: return 32'sd29;
         default: return '0;
      endcase
   endfunction

endpackage

/* design/q2e_front.sv */
// ----------------------------------------------------------------------------
// q2e_front
// Products and sums of the quaternion terms, and the radicand for the
// pitch cosine.
// ----------------------------------------------------------------------------
module q2e_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [q2e_pkg::IN_W-1:0] in_w,
   input  logic signed [q2e_pkg::IN_W-1:0] in_x,
   input  logic signed [q2e_pkg::IN_W-1:0] in_y,
   input  logic signed [q2e_pkg::IN_W-1:0] in_z,
   output logic                            out_valid,
   output q2e_pkg::angle_args_type         out_args,
   output logic [q2e_pkg::RAD_IN_W-1:0]    out_rad
);

   logic [q2e_pkg::FRONT_LAT-1:0] valid_ff;

   logic signed [q2e_pkg::PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff;
   logic signed [q2e_pkg::PROD_W-1:0] wz_ff, xy_ff, zz_ff;

   q2e_pkg::angle_args_type args2_in, args2_ff, args3_in, args3_ff, args4_ff, args5_ff;
   logic [q2e_pkg::MAG_W-1:0]  mag_in, mag_ff;
   logic                       clamp_in;
   logic [q2e_pkg::SQ_W-1:0]   sq_ff;
   logic [q2e_pkg::RAD_IN_W-1:0] rad_ff;
   logic signed [q2e_pkg::Q_W-1:0] abs_sp;

   function automatic logic signed [q2e_pkg::Q_W-1:0] dbl_sum(
      input logic signed [q2e_pkg::PROD_W-1:0] a,
      input logic signed [q2e_pkg::PROD_W-1:0] b
   );
      logic signed [q2e_pkg::Q_W-1:0] s;
      s = q2e_pkg::Q_W'(a) + q2e_pkg::Q_W'(b);
      return s <<< 1;
   endfunction

   always_comb begin
      args2_in.roll_sn  = dbl_sum(wx_ff, yz_ff);
      args2_in.roll_cs  = q2e_pkg::Q_ONE - dbl_sum(xx_ff, yy_ff);
      args2_in.yaw_sn   = dbl_sum(wz_ff, xy_ff);
      args2_in.yaw_cs   = q2e_pkg::Q_ONE - dbl_sum(yy_ff, zz_ff);
      args2_in.pitch_sp = dbl_sum(wy_ff, -zx_ff);
      args2_in.clamp    = 1'b0;
   end

   // pitch argument at or beyond magnitude one is clamped later
   always_comb begin
      abs_sp   = args2_ff.pitch_sp[q2e_pkg::Q_W-1] ? -args2_ff.pitch_sp : args2_ff.pitch_sp;
      clamp_in = (args2_ff.pitch_sp >= q2e_pkg::Q_ONE) || (args2_ff.pitch_sp <= -q2e_pkg::Q_ONE);
      mag_in   = abs_sp[q2e_pkg::MAG_W-1:0];
      args3_in       = args2_ff;
      args3_in.clamp = clamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[q2e_pkg::FRONT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      wx_ff <= in_w * in_x;
      yz_ff <= in_y * in_z;
      xx_ff <= in_x * in_x;
      yy_ff <= in_y * in_y;
      wy_ff <= in_w * in_y;
      zx_ff <= in_z * in_x;
      wz_ff <= in_w * in_z;
      xy_ff <= in_x * in_y;
      zz_ff <= in_z * in_z;
      args2_ff <= args2_in;
      args3_ff <= args3_in;
      mag_ff   <= mag_in;
      args4_ff <= args3_ff;
      sq_ff    <= mag_ff * mag_ff;
      args5_ff <= args4_ff;
      rad_ff   <= {1'b1, {q2e_pkg::SQ_W{1'b0}}} - {1'b0, sq_ff};
   end

   assign out_valid = valid_ff[q2e_pkg::FRONT_LAT-1];
   assign out_args  = args5_ff;
   assign out_rad   = rad_ff;

endmodule

/* design/q2e_sqrt.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined restoring square root, one result bit per stage, with the
// angle arguments carried alongside.
// ----------------------------------------------------------------------------
module q2e_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  q2e_pkg::angle_args_type       in_args,
   input  logic [q2e_pkg::RAD_IN_W-1:0]  in_rad,
   output logic                          out_valid,
   output q2e_pkg::angle_args_type       out_args,
   output logic [q2e_pkg::ROOT_W-1:0]    out_root
);

   logic                          valid_ff [q2e_pkg::ROOT_W];
   q2e_pkg::angle_args_type       args_ff  [q2e_pkg::ROOT_W];
   logic [q2e_pkg::RAD_W-1:0]     rad_ff   [q2e_pkg::ROOT_W];
   logic [q2e_pkg::REM_W-1:0]     rem_ff   [q2e_pkg::ROOT_W];
   logic [q2e_pkg::ROOT_W-1:0]    root_ff  [q2e_pkg::ROOT_W];

   for (genvar g = 0; g < q2e_pkg::ROOT_W; g++) begin : g_stage
      logic                       valid_prev;
      q2e_pkg::angle_args_type    args_prev;
      logic [q2e_pkg::RAD_W-1:0]  rad_prev;
      logic [q2e_pkg::REM_W-1:0]  rem_prev, cur, trial;
      logic [q2e_pkg::ROOT_W-1:0] root_prev;
      logic                       ge;

      if (g == 0) begin : g_first
         assign valid_prev = in_valid;
         assign args_prev  = in_args;
         assign rad_prev   = q2e_pkg::RAD_W'(in_rad);
         assign rem_prev   = '0;
         assign root_prev  = '0;
      end else begin : g_next
         assign valid_prev = valid_ff[g-1];
         assign args_prev  = args_ff[g-1];
         assign rad_prev   = rad_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign root_prev  = root_ff[g-1];
      end

      assign cur   = {rem_prev[q2e_pkg::REM_W-3:0], rad_prev[q2e_pkg::RAD_W-1 -: 2]};
      assign trial = {root_prev, 2'b01};
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         args_ff[g] <= args_prev;
         rad_ff[g]  <= rad_prev << 2;
         rem_ff[g]  <= ge ? cur - trial : cur;
         root_ff[g] <= {root_prev[q2e_pkg::ROOT_W-2:0], ge};
      end
   end

   assign out_valid = valid_ff[q2e_pkg::ROOT_W-1];
   assign out_args  = args_ff[q2e_pkg::ROOT_W-1];
   assign out_root  = root_ff[q2e_pkg::ROOT_W-1];

endmodule

/* design/q2e_cordic.sv */
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring cordic giving atan2(sn, cs) in 2^-22 degree units,
// with a forced result for the special cases.
// ----------------------------------------------------------------------------
module q2e_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [q2e_pkg::Q_W-1:0]    in_sn,
   input  logic signed [q2e_pkg::Q_W-1:0]    in_cs,
   input  logic                              in_force,
   input  logic signed [q2e_pkg::ACC_W-1:0]  in_force_acc,
   output logic                              out_valid,
   output logic signed [q2e_pkg::ACC_W-1:0]  out_acc
);

   logic signed [q2e_pkg::CORDIC_EXT_W-1:0] sn_ext, cs_ext;
   logic signed [q2e_pkg::VEC_W-1:0]   vx_in, vy_in;
   logic signed [q2e_pkg::ACC_W-1:0]   acc_in;
   logic                               hold_in;

   logic                               valid_ff [q2e_pkg::CORDIC_STAGES+1];
   logic                               hold_ff  [q2e_pkg::CORDIC_STAGES+1];
   logic signed [q2e_pkg::VEC_W-1:0]   vx_ff    [q2e_pkg::CORDIC_STAGES+1];
   logic signed [q2e_pkg::VEC_W-1:0]   vy_ff    [q2e_pkg::CORDIC_STAGES+1];
   logic signed [q2e_pkg::ACC_W-1:0]   acc_ff   [q2e_pkg::CORDIC_STAGES+1];

   always_comb begin
      sn_ext = (q2e_pkg::CORDIC_EXT_W'(in_sn) <<< 2) >>> q2e_pkg::VEC_SHIFT;
      cs_ext = (q2e_pkg::CORDIC_EXT_W'(in_cs) <<< 2) >>> q2e_pkg::VEC_SHIFT;
      vx_in   = cs_ext[q2e_pkg::VEC_W-1:0];
      vy_in   = sn_ext[q2e_pkg::VEC_W-1:0];
      acc_in  = '0;
      hold_in = 1'b0;
      if (in_force) begin
         hold_in = 1'b1;
         acc_in  = in_force_acc;
      end else if (in_sn == '0) begin
         hold_in = 1'b1;
         acc_in  = in_cs[q2e_pkg::Q_W-1] ? q2e_pkg::HALF_TURN : '0;
      end else if (in_cs[q2e_pkg::Q_W-1]) begin
         // left half plane: rotate by half a turn first
         vx_in  = -cs_ext[q2e_pkg::VEC_W-1:0];
         vy_in  = -sn_ext[q2e_pkg::VEC_W-1:0];
         acc_in = in_sn[q2e_pkg::Q_W-1] ? -q2e_pkg::HALF_TURN : q2e_pkg::HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff[0] <= hold_in;
      vx_ff[0]   <= vx_in;
      vy_ff[0]   <= vy_in;
      acc_ff[0]  <= acc_in;
   end

   for (genvar i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin : g_stage
      logic signed [q2e_pkg::VEC_W-1:0] dx, dy;
      logic                             pos;

      assign dx  = vy_ff[i] >>> i;
      assign dy  = vx_ff[i] >>> i;
      assign pos = (vy_ff[i] > 0);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         hold_ff[i+1] <= hold_ff[i];
         if (hold_ff[i]) begin
            vx_ff[i+1]  <= vx_ff[i];
            vy_ff[i+1]  <= vy_ff[i];
            acc_ff[i+1] <= acc_ff[i];
         end else if (pos) begin
            vx_ff[i+1]  <= vx_ff[i] + dx;
            vy_ff[i+1]  <= vy_ff[i] - dy;
            acc_ff[i+1] <= acc_ff[i] + q2e_pkg::atan_val(i);
         end else begin
            vx_ff[i+1]  <= vx_ff[i] - dx;
            vy_ff[i+1]  <= vy_ff[i] + dy;
            acc_ff[i+1] <= acc_ff[i] - q2e_pkg::atan_val(i);
         end
      end
   end

   assign out_valid = valid_ff[q2e_pkg::CORDIC_STAGES];
   assign out_acc   = acc_ff[q2e_pkg::CORDIC_STAGES];

endmodule

/* design/quaternion_to_euler_angles.sv */
// a result strobes after its start transfer passes the front, square root, cordic and output registers
// throughput: one quaternion per cycle, busy is never raised
// the pitch square root (29 stages) and the cordic (16 stages) set the depth
// reset clears only the valid bits of the pipeline; no strobe follows reset
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Roll, pitch and yaw in 1/64 degree from a q2.14 unit quaternion.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_w,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_x,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_y,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_z,
   output logic                                rsp_strobe,
   output logic signed [q2e_pkg::ROLL_W-1:0]   rsp_roll_deg,
   output logic signed [q2e_pkg::PITCH_W-1:0]  rsp_pitch_deg,
   output logic [q2e_pkg::YAW_W-1:0]           rsp_yaw_deg
);

   logic                              front_valid, sq_valid;
   q2e_pkg::angle_args_type           front_args, sq_args;
   logic [q2e_pkg::RAD_IN_W-1:0]      front_rad;
   logic [q2e_pkg::ROOT_W-1:0]        sq_root;
   logic                              roll_valid, pitch_valid, yaw_valid;
   logic signed [q2e_pkg::ACC_W-1:0]  roll_acc, pitch_acc, yaw_acc;
   logic signed [q2e_pkg::ACC_W-1:0]  pitch_force_acc;
   logic signed [q2e_pkg::Q_W-1:0]    pitch_cs;

   logic                              strobe_ff;
   logic signed [q2e_pkg::ROLL_W-1:0] roll_in, roll_ff;
   logic signed [q2e_pkg::PITCH_W-1:0] pitch_in, pitch_ff;
   logic [q2e_pkg::YAW_W-1:0]         yaw_in, yaw_ff;
   logic signed [q2e_pkg::ROLL_W-1:0] yaw_s;
   logic signed [q2e_pkg::ROLL_W-1:0] pitch_s;

   function automatic logic signed [q2e_pkg::ROLL_W-1:0] to_units(
      input logic signed [q2e_pkg::ACC_W-1:0] acc,
      input int                               lim
   );
      logic signed [q2e_pkg::ACC_W:0] r;
      r = (q2e_pkg::ACC_W'(acc) + (q2e_pkg::ACC_W+1)'(32768)) >>> 16;
      if (r > (q2e_pkg::ACC_W+1)'(lim)) begin
         r = (q2e_pkg::ACC_W+1)'(lim);
      end else if (r < -(q2e_pkg::ACC_W+1)'(lim)) begin
         r = -(q2e_pkg::ACC_W+1)'(lim);
      end
      return r[q2e_pkg::ROLL_W-1:0];
   endfunction

   assign busy = 1'b0;

   q2e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_w      (req_quat_w),
      .in_x      (req_quat_x),
      .in_y      (req_quat_y),
      .in_z      (req_quat_z),
      .out_valid (front_valid),
      .out_args  (front_args),
      .out_rad   (front_rad)
   );

   q2e_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_args   (front_args),
      .in_rad    (front_rad),
      .out_valid (sq_valid),
      .out_args  (sq_args),
      .out_root  (sq_root)
   );

   assign pitch_cs        = q2e_pkg::Q_W'(sq_root);
   assign pitch_force_acc = sq_args.pitch_sp[q2e_pkg::Q_W-1] ? -q2e_pkg::PITCH_FORCE
                                                             : q2e_pkg::PITCH_FORCE;

   q2e_cordic u_roll (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sq_valid),
      .in_sn        (sq_args.roll_sn),
      .in_cs        (sq_args.roll_cs),
      .in_force     (1'b0),
      .in_force_acc (pitch_force_acc),
      .out_valid    (roll_valid),
      .out_acc      (roll_acc)
   );

   q2e_cordic u_pitch (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sq_valid),
      .in_sn        (sq_args.pitch_sp),
      .in_cs        (pitch_cs),
      .in_force     (sq_args.clamp),
      .in_force_acc (pitch_force_acc),
      .out_valid    (pitch_valid),
      .out_acc      (pitch_acc)
   );

   q2e_cordic u_yaw (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sq_valid),
      .in_sn        (sq_args.yaw_sn),
      .in_cs        (sq_args.yaw_cs),
      .in_force     (1'b0),
      .in_force_acc (pitch_force_acc),
      .out_valid    (yaw_valid),
      .out_acc      (yaw_acc)
   );

   always_comb begin
      roll_in  = to_units(roll_acc, q2e_pkg::ROLL_LIM);
      pitch_s  = to_units(pitch_acc, q2e_pkg::PITCH_LIM);
      pitch_in = pitch_s[q2e_pkg::PITCH_W-1:0];
      yaw_s    = to_units(yaw_acc, q2e_pkg::ROLL_LIM);
      // wrap negative yaw into the upper half turn
      yaw_in   = yaw_s[q2e_pkg::ROLL_W-1]
               ? q2e_pkg::YAW_W'(yaw_s + q2e_pkg::ROLL_W'(q2e_pkg::UNITS_FULL))
               : q2e_pkg::YAW_W'(yaw_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= roll_valid & pitch_valid & yaw_valid;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_in;
      pitch_ff <= pitch_in;
      yaw_ff   <= yaw_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_roll_deg  = roll_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_yaw_deg   = yaw_ff;

endmodule

/* design/q2e_checker.sv */
// ----------------------------------------------------------------------------
// q2e_checker
// Port level checks on the euler angle pipeline: result timing and ranges.
// ----------------------------------------------------------------------------
module q2e_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic signed [q2e_pkg::ROLL_W-1:0]   rsp_roll_deg,
   input logic signed [q2e_pkg::PITCH_W-1:0]  rsp_pitch_deg,
   input logic [q2e_pkg::YAW_W-1:0]           rsp_yaw_deg
);

   // every result traces back to an earlier start transfer taken while busy was low
   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, q2e_pkg::PIPE_LATENCY))
      else $error("result strobe without matching start transfer");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_roll_deg <= q2e_pkg::ROLL_LIM) &&
                     (rsp_roll_deg >= -q2e_pkg::ROLL_LIM))
      else $error("roll out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pitch_deg <= q2e_pkg::PITCH_LIM) &&
                     (rsp_pitch_deg >= -q2e_pkg::PITCH_LIM))
      else $error("pitch out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_yaw_deg < q2e_pkg::UNITS_FULL))
      else $error("yaw out of range");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);

/* tb/quaternion_to_euler_angles_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives quaternions into the euler angle pipeline and compares each roll,
// pitch and yaw strobe against a fixed-point cordic predictor kept here.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  STAGES      = 16;
   localparam int  FBITS       = 14;
   localparam longint ONE28    = 64'sd268435456;
   localparam longint HALF_ANG = 64'sd754974720;
   localparam int  RANDOM_ITEMS = 1300;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [14:0] roll;
      logic signed [13:0] pitch;
      logic [14:0]        yaw;
   } angles_type;

   // arctangent table in 2^-22 degree
   localparam longint ATAN_LUT [0:23] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint sn, longint cs);
      longint vx, vy, acc, dx, dy;
      acc = 0;
      if (sn == 0) return (cs < 0) ? HALF_ANG : 0;
      vx = floor_shift(cs * 4, 30 - FBITS);
      vy = floor_shift(sn * 4, 30 - FBITS);
      if (cs < 0) begin
         acc = (sn > 0) ? HALF_ANG : -HALF_ANG;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shift(vy, i);
         dy = floor_shift(vx, i);
         if (vy > 0) begin
            vx += dx; vy -= dy; acc += ATAN_LUT[i];
         end else begin
            vx -= dx; vy += dy; acc -= ATAN_LUT[i];
         end
      end
      return acc;
   endfunction

   function automatic longint sixtyfourths(longint acc, longint lim);
      longint r;
      r = floor_shift(acc + 32768, 16);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                                 logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, sp, rl, pt, yw;
      longint unsigned mag;
      angles_type a;
      w = qw; x = qx; y = qy; z = qz;
      rl = sixtyfourths(vector_angle(2 * (w * x + y * z), ONE28 - 2 * (x * x + y * y)),
                        q2e_pkg::ROLL_LIM);
      sp = 2 * (w * y - z * x);
      if (sp >= ONE28) pt = q2e_pkg::PITCH_LIM;
      else if (sp <= -ONE28) pt = -q2e_pkg::PITCH_LIM;
      else begin
         mag = (sp < 0) ? -sp : sp;
         pt = sixtyfourths(vector_angle(sp, root_floor((64'd1 << 56) - mag * mag)),
                           q2e_pkg::PITCH_LIM);
      end
      yw = sixtyfourths(vector_angle(2 * (w * z + x * y), ONE28 - 2 * (y * y + z * z)),
                        q2e_pkg::ROLL_LIM);
      if (yw < 0) yw += q2e_pkg::UNITS_FULL;
      a.roll = rl[14:0];
      a.pitch = pt[13:0];
      a.yaw = yw[14:0];
      return a;
   endfunction

   class angle_scoreboard;
      angles_type pending_angles[$];
      int errors;
      int mismatches;

      function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                              logic signed [15:0] qy, logic signed [15:0] qz);
         pending_angles.push_back(predict_angles(qw, qx, qy, qz));
      endfunction

      function void check_angles(angles_type got);
         angles_type exp_a;
         if (pending_angles.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer");
            return;
         end
         exp_a = pending_angles.pop_front();
         if (exp_a.roll !== got.roll || exp_a.pitch !== got.pitch || exp_a.yaw !== got.yaw)
         begin
            mismatches++;
            errors++;
            if (mismatches <= 10)
               $display("mismatch: exp roll %0d pitch %0d yaw %0d, got roll %0d pitch %0d yaw %0d",
                        exp_a.roll, exp_a.pitch, exp_a.yaw, got.roll, got.pitch, got.yaw);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_strobe;
   logic signed [14:0] rsp_roll_deg;
   logic signed [13:0] rsp_pitch_deg;
   logic [14:0] rsp_yaw_deg;

   angle_scoreboard board = new();
   int idle_pct;
   longint cycle_count;

   quaternion_to_euler_angles u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // results and accepted inputs are taken at the edge, before the drivers update
   always @(posedge clock) begin
      angles_type got;
      if (!reset) begin
         if (rsp_strobe) begin
            got.roll = rsp_roll_deg;
            got.pitch = rsp_pitch_deg;
            got.yaw = rsp_yaw_deg;
            board.check_angles(got);
         end
         if (start && !busy) board.note_quat(req_quat_w, req_quat_x, req_quat_y, req_quat_z);
      end
   end

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'(16384);
         1: return -16'sd16384;
         2: return 16'($urandom);
         3: return 16'sd0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // one transfer; a random gap is inserted before it, start is held otherwise
   task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_quat_w <= qw;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // roughly unit quaternion from random half-angle components
   task automatic send_unit_quat();
      real a, b, c, d, n;
      a = $urandom_range(0, 20000) - 10000.0;
      b = $urandom_range(0, 20000) - 10000.0;
      c = $urandom_range(0, 20000) - 10000.0;
      d = $urandom_range(0, 20000) - 10000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
                16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)));
   endtask

   initial begin
      int wait_cycles;
      cycle_count = 0;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: identity, axis turns, gimbal lock, zero and extreme patterns
      send_quat(16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(-16384, 0, 0, 0);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(11585, -11585, 0, 0);
      send_quat(11585, 0, 0, -11585);
      send_quat(8192, 8192, 8192, 8192);
      send_quat(8192, -8192, 8192, -8192);
      send_quat(0, 0, 0, 0);
      send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_quat(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(16383, 1, -1, 0);
      send_quat(0, -11585, 0, 11585);
      send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 27 : (phase == 1) ? 79 : 0;
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
            if ($urandom_range(0, 99) < 70) send_unit_quat();
            else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         end
      end
      start <= 1'b0;
      wait_cycles = 0;
      while (board.pending_angles.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending_angles.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

/* quaternion_to_euler_angles.f */
design/q2e_pkg.sv
design/q2e_front.sv
design/q2e_sqrt.sv
design/q2e_cordic.sv
design/quaternion_to_euler_angles.sv
design/q2e_checker.sv
tb/quaternion_to_euler_angles_tb.sv
